// ===== rtl/sgl_pkg.sv =====
// Shared types, code tables and constants of the SJIS glyph layout block.
package sgl_pkg;

   typedef enum logic [2:0] {
      KIND_LEAD    = 3'd0,
      KIND_GLYPH   = 3'd1,
      KIND_ADVANCE = 3'd2,
      KIND_NEWLINE = 3'd3,
      KIND_IGNORED = 3'd4
   } kind_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FULL_ADVANCE = 2'd0;
   localparam logic [1:0] CSR_HALF_ADVANCE = 2'd1;
   localparam logic [1:0] CSR_LINE_PITCH   = 2'd2;

   localparam logic [7:0] RESET_FULL_ADVANCE = 8'd24;
   localparam logic [7:0] RESET_HALF_ADVANCE = 8'd12;
   localparam logic [7:0] RESET_LINE_PITCH   = 8'd31;

   localparam logic [7:0]  BYTE_NEWLINE     = 8'h0a;
   localparam logic [7:0]  BYTE_SPACE       = 8'h20;
   localparam logic [7:0]  BYTE_ASCII_FIRST = 8'h21;
   localparam logic [7:0]  BYTE_ASCII_LAST  = 8'h7e;
   localparam logic [7:0]  BYTE_KANA_FIRST  = 8'ha1;
   localparam logic [7:0]  BYTE_KANA_LAST   = 8'hdf;
   localparam logic [15:0] CODE_WIDE_SPACE  = 16'h8140;
   localparam logic [12:0] HALF_SPACE_INDEX = 13'd157;
   localparam logic [12:0] HALF_KANA_BASE   = 13'd94;

   localparam int RANGE_COUNT = 52;
   localparam int RNG_W       = 6;

   localparam logic [15:0] RNG_LO [RANGE_COUNT] = '{
      16'h8141, 16'h81b8, 16'h81c8, 16'h81da, 16'h824f, 16'h8260, 16'h8281, 16'h829f,
      16'h8340, 16'h839f, 16'h83bf, 16'h8440, 16'h8470, 16'h849f, 16'h8740, 16'h889f,
      16'h8940, 16'h8a40, 16'h8b40, 16'h8c40, 16'h8d40, 16'h8e40, 16'h8f40, 16'h9040,
      16'h9140, 16'h9240, 16'h9340, 16'h9440, 16'h9540, 16'h9640, 16'h9740, 16'h9840,
      16'h989f, 16'h9940, 16'h9a40, 16'h9b40, 16'h9c40, 16'h9d40, 16'h9e40, 16'h9f40,
      16'he040, 16'he140, 16'he240, 16'he340, 16'he440, 16'he540, 16'he640, 16'he740,
      16'he840, 16'he940, 16'hea40, 16'hf040
   };

   localparam logic [15:0] RNG_HI [RANGE_COUNT] = '{
      16'h81ac, 16'h81bf, 16'h81ce, 16'h81fc, 16'h8258, 16'h8279, 16'h829a, 16'h82f1,
      16'h8396, 16'h83b6, 16'h83d6, 16'h8460, 16'h8491, 16'h84be, 16'h8799, 16'h88fc,
      16'h89fc, 16'h8afc, 16'h8bfc, 16'h8cfc, 16'h8dfc, 16'h8efc, 16'h8ffc, 16'h90fc,
      16'h91fc, 16'h92fc, 16'h93fc, 16'h94fc, 16'h95fc, 16'h96fc, 16'h97fc, 16'h9872,
      16'h98fc, 16'h99fc, 16'h9afc, 16'h9bfc, 16'h9cfc, 16'h9dfc, 16'h9efc, 16'h9ffc,
      16'he0fc, 16'he1fc, 16'he2fc, 16'he3fc, 16'he4fc, 16'he5fc, 16'he6fc, 16'he7fc,
      16'he8fc, 16'he9fc, 16'heaa4, 16'hf047
   };

   localparam logic [12:0] RNG_BASE [RANGE_COUNT] = '{
      13'd0,    13'd108,  13'd116,  13'd123,  13'd158,  13'd168,  13'd194,  13'd220,
      13'd303,  13'd390,  13'd414,  13'd438,  13'd471,  13'd505,  13'd537,  13'd627,
      13'd721,  13'd910,  13'd1099, 13'd1288, 13'd1477, 13'd1666, 13'd1855, 13'd2044,
      13'd2233, 13'd2422, 13'd2611, 13'd2800, 13'd2989, 13'd3178, 13'd3367, 13'd3556,
      13'd3607, 13'd3701, 13'd3890, 13'd4079, 13'd4268, 13'd4457, 13'd4646, 13'd4835,
      13'd5024, 13'd5213, 13'd5402, 13'd5591, 13'd5780, 13'd5969, 13'd6158, 13'd6347,
      13'd6536, 13'd6725, 13'd6914, 13'd7015
   };

   // One classified byte on its way from the front end to the back end.
   typedef struct packed {
      kind_type             kind;
      logic                 full;
      logic [RNG_W-1:0]     rng;
      logic [15:0]          code;
      logic signed [15:0]   pen_x;
      logic signed [15:0]   pen_y;
   } entry_type;

endpackage

// ===== rtl/sgl_front.sv =====
// Front end: configuration registers, lead byte pairing, range match and pen tracking.
module sgl_front #(
   parameter int FULL_GLYPHS = 7023
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  accept,
   input  logic [7:0]            char_byte,
   input  logic                  first_byte,
   input  logic                  last_byte,
   input  logic signed [15:0]    origin_x,
   input  logic signed [15:0]    origin_y,
   output sgl_pkg::entry_type    entry
);
   import sgl_pkg::*;

   logic [7:0]         full_adv_ff, half_adv_ff, pitch_ff;
   logic               held_ff, held_in;
   logic [7:0]         held_byte_ff, held_byte_in;
   logic signed [15:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, line_x_ff, line_x_in;

   logic               held_now;
   logic signed [15:0] pen_x, pen_y, line_x;
   logic [15:0]        code;
   logic signed [17:0] code_s;
   logic [RANGE_COUNT-1:0] hit;
   logic [RNG_W-1:0]   rng;

   assign held_now = first_byte ? 1'b0 : held_ff;
   assign pen_x    = first_byte ? origin_x : cur_x_ff;
   assign pen_y    = first_byte ? origin_y : cur_y_ff;
   assign line_x   = first_byte ? origin_x : line_x_ff;
   assign code     = {held_byte_ff, char_byte};
   assign code_s   = {2'b00, code};

   // Each range is cut short where its indexes would reach past the glyph set.
   for (genvar g = 0; g < RANGE_COUNT; g++) begin : g_rng
      localparam int Lo    = int'(RNG_LO[g]);
      localparam int Hi    = int'(RNG_HI[g]);
      localparam int Room  = FULL_GLYPHS - int'(RNG_BASE[g]);
      localparam int Cap   = Lo + Room - 1;
      localparam int HiLim = (Room <= 0) ? -1 : ((Cap < Hi) ? Cap : Hi);
      localparam logic signed [17:0] LoS = 18'(Lo);
      localparam logic signed [17:0] HiS = 18'(HiLim);
      assign hit[g] = (code_s >= LoS) && (code_s <= HiS);
   end

   always_comb begin
      rng = '0;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         if (hit[i]) begin
            rng = rng | RNG_W'(i);
         end
      end
   end

   always_comb begin
      held_in      = held_now;
      held_byte_in = held_byte_ff;
      cur_x_in     = pen_x;
      cur_y_in     = pen_y;
      line_x_in    = line_x;
      entry.kind   = KIND_IGNORED;
      entry.full   = 1'b0;
      entry.rng    = rng;
      entry.code   = code;
      entry.pen_x  = pen_x;
      entry.pen_y  = pen_y;
      if (held_now) begin
         held_in = 1'b0;
         if (|hit) begin
            entry.kind = KIND_GLYPH;
            entry.full = 1'b1;
            cur_x_in   = pen_x + $signed({8'd0, full_adv_ff});
         end else if (code == CODE_WIDE_SPACE) begin
            entry.kind = KIND_ADVANCE;
            cur_x_in   = pen_x + $signed({8'd0, full_adv_ff});
         end
      end else if (char_byte == BYTE_NEWLINE) begin
         entry.kind = KIND_NEWLINE;
         cur_x_in   = line_x;
         cur_y_in   = pen_y + $signed({8'd0, pitch_ff});
      end else if (char_byte inside {[8'h81:8'h9f], [8'he0:8'hea], 8'hf0}) begin
         if (!last_byte) begin
            entry.kind   = KIND_LEAD;
            held_in      = 1'b1;
            held_byte_in = char_byte;
         end
      end else if (char_byte inside {[BYTE_ASCII_FIRST:BYTE_ASCII_LAST],
                                     [BYTE_KANA_FIRST:BYTE_KANA_LAST], BYTE_SPACE}) begin
         entry.kind = KIND_GLYPH;
         cur_x_in   = pen_x + $signed({8'd0, half_adv_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_adv_ff  <= RESET_FULL_ADVANCE;
         half_adv_ff  <= RESET_HALF_ADVANCE;
         pitch_ff     <= RESET_LINE_PITCH;
         held_ff      <= 1'b0;
         held_byte_ff <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         line_x_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FULL_ADVANCE: full_adv_ff <= csr_wdata;
               CSR_HALF_ADVANCE: half_adv_ff <= csr_wdata;
               CSR_LINE_PITCH:   pitch_ff    <= csr_wdata;
               default:          ;
            endcase
         end
         if (accept) begin
            held_ff      <= held_in;
            held_byte_ff <= held_byte_in;
            cur_x_ff     <= cur_x_in;
            cur_y_ff     <= cur_y_in;
            line_x_ff    <= line_x_in;
         end
      end
   end

endmodule

// ===== rtl/sgl_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module sgl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sgl_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output sgl_pkg::entry_type  pop_entry
);
   import sgl_pkg::*;

   entry_type   slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/sgl_back.sv =====
// Back end: glyph index in one stage, font memory address in the output register.
module sgl_back #(
   parameter int FULL_GLYPHS     = 7023,
   parameter int FULL_CELL_BYTES = 288,
   parameter int HALF_CELL_BYTES = 144
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  sgl_pkg::entry_type  pop_entry,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output sgl_pkg::kind_type   out_kind,
   output logic                out_full,
   output logic [12:0]         out_index,
   output logic [20:0]         out_address,
   output logic signed [15:0]  out_pen_x,
   output logic signed [15:0]  out_pen_y
);
   import sgl_pkg::*;

   localparam logic [10:0] FullBytes = 11'(FULL_CELL_BYTES);
   localparam logic [10:0] HalfBytes = 11'(HALF_CELL_BYTES);
   localparam logic [20:0] HalfBase  = 21'((FULL_GLYPHS * FULL_CELL_BYTES) % (1 << 21));

   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic               s1_full_ff;
   logic [12:0]        s1_index_ff, s1_index_in;
   logic signed [15:0] s1_pen_x_ff, s1_pen_y_ff;
   logic               s1_move, s2_move;
   logic [15:0]        full_off;
   logic [7:0]         b;
   logic [23:0]        product;
   logic [20:0]        address_in;

   assign s2_move = !out_valid || out_ready;
   assign s1_move = s1_valid_ff && s2_move;
   assign pop     = !s1_valid_ff || s2_move;
   assign b       = pop_entry.code[7:0];

   always_comb begin
      full_off = '0;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         if (pop_entry.rng == RNG_W'(i)) begin
            full_off = pop_entry.code - RNG_LO[i] + {3'd0, RNG_BASE[i]};
         end
      end
      s1_index_in = '0;
      if (pop_entry.kind == KIND_GLYPH) begin
         if (pop_entry.full) begin
            s1_index_in = full_off[12:0];
         end else if (b == BYTE_SPACE) begin
            s1_index_in = HALF_SPACE_INDEX;
         end else if (b <= BYTE_ASCII_LAST) begin
            s1_index_in = {5'd0, b - BYTE_ASCII_FIRST};
         end else begin
            s1_index_in = HALF_KANA_BASE + {5'd0, b - BYTE_KANA_FIRST};
         end
      end
   end

   assign product = {11'd0, s1_index_ff} * {13'd0, s1_full_ff ? FullBytes : HalfBytes};

   always_comb begin
      address_in = '0;
      if (s1_kind_ff == KIND_GLYPH) begin
         address_in = product[20:0] + (s1_full_ff ? 21'd0 : HalfBase);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid   <= 1'b0;
      end else begin
         if (pop) begin
            s1_valid_ff <= pop_valid;
         end
         if (s2_move) begin
            out_valid <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_valid) begin
         s1_kind_ff  <= pop_entry.kind;
         s1_full_ff  <= pop_entry.full;
         s1_index_ff <= s1_index_in;
         s1_pen_x_ff <= pop_entry.pen_x;
         s1_pen_y_ff <= pop_entry.pen_y;
      end
      if (s1_move) begin
         out_kind    <= s1_kind_ff;
         out_full    <= s1_full_ff;
         out_index   <= s1_index_ff;
         out_address <= address_in;
         out_pen_x   <= s1_pen_x_ff;
         out_pen_y   <= s1_pen_y_ff;
      end
   end

endmodule

// ===== rtl/sjis_glyph_layout.sv =====
// Top level of the SJIS glyph layout block.
// Takes one CP932 byte per transaction and returns one result per byte, in order, at
// one byte per cycle sustained while rsp_tready stays high. The rate is set by the front
// end's combinational pen and lead byte update, where all 52 code ranges are compared in
// parallel. Each byte passes from the two-entry queue through the index stage and then
// waits in the output register. A lead byte that is not the last of its string yields a
// result of kind 0 and pairs with the next byte, which is consumed as its trail whatever
// its value, unless that byte starts a new string.
module sjis_glyph_layout #(
   parameter int FULL_GLYPHS     = 7023,
   parameter int FULL_CELL_BYTES = 288,
   parameter int HALF_CELL_BYTES = 144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // char_byte[7:0], origin_x[23:8], origin_y[39:24]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // glyph_number[12:0], glyph_address[33:13],
                                    // pen_x[49:34], pen_y[65:50], zeros above
   output logic [3:0]  rsp_tuser    // kind[2:0], full_width[3]
);
   import sgl_pkg::*;

   entry_type          push_entry, pop_entry;
   logic               q_ready, pop, pop_valid, accept;
   kind_type           out_kind;
   logic               out_full;
   logic [12:0]        out_index;
   logic [20:0]        out_address;
   logic signed [15:0] out_pen_x, out_pen_y;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   sgl_front #(
      .FULL_GLYPHS (FULL_GLYPHS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .char_byte  (req_tdata[7:0]),
      .first_byte (req_tuser),
      .last_byte  (req_tlast),
      .origin_x   (req_tdata[23:8]),
      .origin_y   (req_tdata[39:24]),
      .entry      (push_entry)
   );

   sgl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   sgl_back #(
      .FULL_GLYPHS     (FULL_GLYPHS),
      .FULL_CELL_BYTES (FULL_CELL_BYTES),
      .HALF_CELL_BYTES (HALF_CELL_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (out_kind),
      .out_full    (out_full),
      .out_index   (out_index),
      .out_address (out_address),
      .out_pen_x   (out_pen_x),
      .out_pen_y   (out_pen_y)
   );

   assign rsp_tdata = {6'd0, out_pen_y, out_pen_x, out_address, out_index};
   assign rsp_tuser = {out_full, out_kind};

endmodule

// ===== rtl/sgl_checker.sv =====
// Port-level checker of the SJIS glyph layout block and its bind statement.
module sgl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);
   import sgl_pkg::*;

   // A result held back by the sink must stay offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction withdrawn while stalled");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Only glyph results carry an index, an address or the full-width flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] != KIND_GLYPH) |->
         (rsp_tdata[33:0] == 34'd0) && !rsp_tuser[3])
      else $error("non-glyph result carries glyph fields");

   // Half-width indexes stay within the half-width set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == KIND_GLYPH) && !rsp_tuser[3] |->
         rsp_tdata[12:0] <= HALF_SPACE_INDEX)
      else $error("half-width index out of range");

   // Padding above the packed fields stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:66] == 6'd0)
      else $error("result padding not zero");

endmodule

bind sjis_glyph_layout sgl_checker u_sgl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sjis_glyph_layout_tb.sv =====
// Self-checking testbench for the SJIS glyph layout block, predicted byte by byte.
module sjis_glyph_layout_tb;
   import sgl_pkg::*;

   localparam int FULL_GLYPHS     = 7023;
   localparam int FULL_CELL_BYTES = 288;
   localparam int HALF_CELL_BYTES = 144;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 120;
   localparam int TOTAL_BYTES = 1650;

   // Full-width code segments: first code, last code and index of the first code.
   localparam int SEGMENTS = 52;
   localparam logic [15:0] SEG_FIRST [SEGMENTS] = '{
      16'h8141, 16'h81b8, 16'h81c8, 16'h81da, 16'h824f, 16'h8260, 16'h8281, 16'h829f,
      16'h8340, 16'h839f, 16'h83bf, 16'h8440, 16'h8470, 16'h849f, 16'h8740, 16'h889f,
      16'h8940, 16'h8a40, 16'h8b40, 16'h8c40, 16'h8d40, 16'h8e40, 16'h8f40, 16'h9040,
      16'h9140, 16'h9240, 16'h9340, 16'h9440, 16'h9540, 16'h9640, 16'h9740, 16'h9840,
      16'h989f, 16'h9940, 16'h9a40, 16'h9b40, 16'h9c40, 16'h9d40, 16'h9e40, 16'h9f40,
      16'he040, 16'he140, 16'he240, 16'he340, 16'he440, 16'he540, 16'he640, 16'he740,
      16'he840, 16'he940, 16'hea40, 16'hf040
   };
   localparam logic [15:0] SEG_LAST [SEGMENTS] = '{
      16'h81ac, 16'h81bf, 16'h81ce, 16'h81fc, 16'h8258, 16'h8279, 16'h829a, 16'h82f1,
      16'h8396, 16'h83b6, 16'h83d6, 16'h8460, 16'h8491, 16'h84be, 16'h8799, 16'h88fc,
      16'h89fc, 16'h8afc, 16'h8bfc, 16'h8cfc, 16'h8dfc, 16'h8efc, 16'h8ffc, 16'h90fc,
      16'h91fc, 16'h92fc, 16'h93fc, 16'h94fc, 16'h95fc, 16'h96fc, 16'h97fc, 16'h9872,
      16'h98fc, 16'h99fc, 16'h9afc, 16'h9bfc, 16'h9cfc, 16'h9dfc, 16'h9efc, 16'h9ffc,
      16'he0fc, 16'he1fc, 16'he2fc, 16'he3fc, 16'he4fc, 16'he5fc, 16'he6fc, 16'he7fc,
      16'he8fc, 16'he9fc, 16'heaa4, 16'hf047
   };
   localparam int SEG_INDEX [SEGMENTS] = '{
         0,  108,  116,  123,  158,  168,  194,  220,
       303,  390,  414,  438,  471,  505,  537,  627,
       721,  910, 1099, 1288, 1477, 1666, 1855, 2044,
      2233, 2422, 2611, 2800, 2989, 3178, 3367, 3556,
      3607, 3701, 3890, 4079, 4268, 4457, 4646, 4835,
      5024, 5213, 5402, 5591, 5780, 5969, 6158, 6347,
      6536, 6725, 6914, 7015
   };

   typedef struct packed {
      kind_type    kind;
      logic        full_width;
      logic [12:0] glyph_number;
      logic [20:0] glyph_address;
      logic [15:0] pen_x;
      logic [15:0] pen_y;
   } placement_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // char_byte[7:0], origin_x[23:8], origin_y[39:24]
   logic        req_tuser = 1'b0; // first_byte
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // glyph_number[12:0], glyph_address[33:13],
                                  // pen_x[49:34], pen_y[65:50], zeros above
   logic [3:0]  rsp_tuser;        // kind[2:0], full_width[3]

   // Predictor state and register shadows.
   logic [7:0]  full_adv = RESET_FULL_ADVANCE;
   logic [7:0]  half_adv = RESET_HALF_ADVANCE;
   logic [7:0]  pitch    = RESET_LINE_PITCH;
   logic        lead_pending = 1'b0;
   logic [7:0]  lead_byte = '0;
   logic [15:0] cur_x = '0, cur_y = '0, line_x = '0;

   placement_type expected_layout [$];
   placement_type want;
   logic [7:0]    text_buf [$];

   int errors = 0, bytes_sent = 0, strings_sent = 0, input_stalls = 0, cfg_writes = 0;
   int full_seen = 0, results_seen = 0;
   int kind_seen [5] = '{0, 0, 0, 0, 0};
   int burst_left = 0, hold_left = 0, mode_left = 0, rx_phase = 0;
   bit gaps_off = 1'b0, hold_request = 1'b0;
   rx_mode_type rx_mode = RX_OPEN;

   sjis_glyph_layout #(
      .FULL_GLYPHS(FULL_GLYPHS),
      .FULL_CELL_BYTES(FULL_CELL_BYTES),
      .HALF_CELL_BYTES(HALF_CELL_BYTES)
   ) DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic bit is_lead_byte(input logic [7:0] b);
      return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hea) || b == 8'hf0;
   endfunction

   // Index of a full-width code, or -1 when it lies in no segment.
   function automatic int full_index(input logic [15:0] code);
      for (int i = 0; i < SEGMENTS; i++) begin
         if (code >= SEG_FIRST[i] && code <= SEG_LAST[i])
            return SEG_INDEX[i] + int'(code - SEG_FIRST[i]);
      end
      return -1;
   endfunction

   // Applies one accepted byte to the pen and lead state and returns its placement.
   function automatic placement_type layout_byte(input logic [7:0] b, input logic first,
                                                 input logic last, input logic [15:0] ox,
                                                 input logic [15:0] oy);
      placement_type r;
      logic [15:0]   code;
      logic [12:0]   half_idx;
      int            fi;
      r.kind = KIND_IGNORED;
      r.full_width = 1'b0;
      r.glyph_number = '0;
      r.glyph_address = '0;
      if (first) begin
         cur_x = ox;
         cur_y = oy;
         line_x = ox;
         lead_pending = 1'b0;
      end
      r.pen_x = cur_x;
      r.pen_y = cur_y;
      if (lead_pending) begin
         // Within a string, the byte after a lead is always its trail, whatever its value.
         code = {lead_byte, b};
         lead_pending = 1'b0;
         fi = full_index(code);
         if (fi >= 0 && fi < FULL_GLYPHS) begin
            r.kind = KIND_GLYPH;
            r.full_width = 1'b1;
            r.glyph_number = fi[12:0];
            r.glyph_address = 21'(fi * FULL_CELL_BYTES);
            cur_x = cur_x + 16'(full_adv);
         end else if (code == CODE_WIDE_SPACE) begin
            r.kind = KIND_ADVANCE;
            cur_x = cur_x + 16'(full_adv);
         end
      end else if (b == BYTE_NEWLINE) begin
         r.kind = KIND_NEWLINE;
         cur_x = line_x;
         cur_y = cur_y + 16'(pitch);
      end else if (is_lead_byte(b)) begin
         if (!last) begin
            lead_pending = 1'b1;
            lead_byte = b;
            r.kind = KIND_LEAD;
         end
      end else if (b == BYTE_SPACE || (b >= BYTE_ASCII_FIRST && b <= BYTE_ASCII_LAST) ||
                   (b >= BYTE_KANA_FIRST && b <= BYTE_KANA_LAST)) begin
         if (b == BYTE_SPACE) half_idx = HALF_SPACE_INDEX;
         else if (b <= BYTE_ASCII_LAST) half_idx = 13'(b - BYTE_ASCII_FIRST);
         else half_idx = HALF_KANA_BASE + 13'(b - BYTE_KANA_FIRST);
         r.kind = KIND_GLYPH;
         r.glyph_number = half_idx;
         r.glyph_address = 21'(FULL_GLYPHS * FULL_CELL_BYTES + half_idx * HALF_CELL_BYTES);
         cur_x = cur_x + 16'(half_adv);
      end
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] expected_val,
                                         input logic [31:0] actual_val);
      if (actual_val !== expected_val) begin
         errors++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected_val, actual_val);
      end
   endfunction

   // Input side: predict every accepted byte.
   always @(posedge clock) begin
      if (!reset && req_tvalid) begin
         if (req_tready) begin
            expected_layout.push_back(layout_byte(req_tdata[7:0], req_tuser, req_tlast,
                                                  req_tdata[23:8], req_tdata[39:24]));
            bytes_sent++;
         end else begin
            input_stalls++;
         end
      end
   end

   // Output side: compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_layout.size() == 0) begin
            errors++;
            $error("result with no expectation waiting: kind %0d, index %0d",
                   rsp_tuser[2:0], rsp_tdata[12:0]);
         end else begin
            want = expected_layout.pop_front();
            results_seen++;
            kind_seen[int'(want.kind)]++;
            if (want.full_width) full_seen++;
            compare_field("kind", 32'(want.kind), 32'(rsp_tuser[2:0]));
            compare_field("full_width", 32'(want.full_width), 32'(rsp_tuser[3]));
            compare_field("glyph_number", 32'(want.glyph_number), 32'(rsp_tdata[12:0]));
            compare_field("glyph_address", 32'(want.glyph_address), 32'(rsp_tdata[33:13]));
            compare_field("pen_x", 32'(want.pen_x), 32'(rsp_tdata[49:34]));
            compare_field("pen_y", 32'(want.pen_y), 32'(rsp_tdata[65:50]));
            compare_field("tdata padding", 32'd0, 32'(rsp_tdata[71:66]));
         end
      end
   end

   // Result receiver: changing stall patterns plus an occasional long hold-off.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      rx_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= (rx_phase % 4 == 0);
            default:   rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Called right after a rising edge; returns right after the edge that took the byte,
   // possibly followed by a gap. The valid stays high when no gap is taken.
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic [15:0] ox, input logic [15:0] oy);
      req_tvalid <= 1'b1;
      req_tdata <= {oy, ox, b};
      req_tuser <= first;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!gaps_off) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops sending and waits until every predicted result has been checked.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_layout.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cfg_writes++;
      case (idx)
         CSR_FULL_ADVANCE: full_adv = val;
         CSR_HALF_ADVANCE: half_adv = val;
         CSR_LINE_PITCH:   pitch = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] fa, input logic [7:0] ha,
                                 input logic [7:0] lp);
      write_reg(CSR_FULL_ADVANCE, fa);
      write_reg(CSR_HALF_ADVANCE, ha);
      write_reg(CSR_LINE_PITCH, lp);
   endtask

   function automatic logic [7:0] random_lead();
      int pick;
      pick = $urandom_range(0, 43);
      if (pick < 31) return 8'(8'h81 + pick);
      if (pick < 42) return 8'(8'he0 + pick - 31);
      return 8'hf0;
   endfunction

   function automatic logic [15:0] random_origin();
      case ($urandom_range(0, 7))
         0:       return 16'(16'h7f00 + $urandom_range(0, 255));
         1:       return 16'(16'hff00 + $urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   // Fills the text buffer with mostly well-formed text and some noise.
   task automatic compose_text(input int len);
      int          pick, seg;
      logic [15:0] code;
      text_buf.delete();
      while (text_buf.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            seg = $urandom_range(0, SEGMENTS - 1);
            code = SEG_FIRST[seg] + 16'($urandom_range(0, SEG_LAST[seg] - SEG_FIRST[seg]));
            text_buf.push_back(code[15:8]);
            text_buf.push_back(code[7:0]);
         end else if (pick < 75) begin
            if ($urandom_range(0, 1))
               text_buf.push_back(8'($urandom_range(BYTE_KANA_FIRST, BYTE_KANA_LAST)));
            else
               text_buf.push_back(8'($urandom_range(BYTE_SPACE, BYTE_ASCII_LAST)));
         end else if (pick < 80) begin
            text_buf.push_back(BYTE_NEWLINE);
         end else if (pick < 85) begin
            text_buf.push_back(CODE_WIDE_SPACE[15:8]);
            text_buf.push_back(CODE_WIDE_SPACE[7:0]);
         end else if (pick < 90) begin
            text_buf.push_back(random_lead());
            text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      // A lone lead at the end of a closed string is not held by the block but yields an ignored result.
      if ($urandom_range(0, 19) == 0) text_buf.push_back(random_lead());
   endtask

   task automatic send_text(input bit close);
      for (int i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], i == 0, close && i == text_buf.size() - 1,
                   random_origin(), random_origin());
      strings_sent++;
   endtask

   task automatic run_strings(input int count);
      repeat (count) begin
         compose_text($urandom_range(8, 20));
         send_text(1'b1);
      end
   endtask

   // Every byte class, the extremes of the tables and the string boundary cases.
   task automatic test_directed();
      send_byte(8'h41, 1'b1, 1'b0, 16'h7ff0, 16'h8000);
      send_byte(BYTE_SPACE, 1'b0, 1'b0, 16'h0, 16'h0);      // pen x wraps past the top
      send_byte(BYTE_ASCII_FIRST, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(BYTE_ASCII_LAST, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(BYTE_KANA_FIRST, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(BYTE_KANA_LAST, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h81, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h40, 1'b0, 1'b0, 16'h0, 16'h0);           // full-width space
      send_byte(8'h81, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h41, 1'b0, 1'b0, 16'h0, 16'h0);           // first full-width glyph
      send_byte(8'hf0, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h47, 1'b0, 1'b0, 16'h0, 16'h0);           // last full-width glyph
      send_byte(8'hea, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'ha5, 1'b0, 1'b0, 16'h0, 16'h0);           // code in no segment
      send_byte(8'h9f, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(BYTE_NEWLINE, 1'b0, 1'b0, 16'h0, 16'h0);   // newline taken as a trail
      send_byte(BYTE_NEWLINE, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h00, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'hff, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h80, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'ha0, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'he0, 1'b0, 1'b1, 16'h0, 16'h0);           // lead on the last byte
      send_byte(8'h88, 1'b0, 1'b0, 16'h0, 16'h0);
      send_byte(8'h31, 1'b1, 1'b0, 16'hffff, 16'h7fff);     // new string drops held lead
      send_byte(8'hfd, 1'b0, 1'b1, 16'h0, 16'h0);
      drain();
   endtask

   task automatic test_register_extremes();
      apply_settings(8'd1, 8'd1, 8'd1);
      run_strings(3);
      drain();
      apply_settings(8'd255, 8'd255, 8'd255);
      run_strings(3);
      drain();
      apply_settings(8'd255, 8'd1, 8'd128);
      write_reg(CSR_SPARE, 8'($urandom_range(0, 255)));   // unused index changes nothing
      run_strings(3);
      drain();
      apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)));
      run_strings(3);
      drain();
   endtask

   // The receiver holds off while the sender keeps offering, so the block backs up.
   task automatic test_backpressure();
      gaps_off = 1'b1;
      hold_request = 1'b1;
      compose_text(40);
      send_text(1'b1);
      gaps_off = 1'b0;
      drain();
   endtask

   task automatic test_random_text();
      int since_cfg;
      since_cfg = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         if (since_cfg >= 300) begin
            drain();
            apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                           8'($urandom_range(1, 255)));
            gaps_off = ($urandom_range(0, 3) == 0);
            since_cfg = 0;
         end
         compose_text(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 24));
         // Now and then a string is left open, so the next one may start on a held lead.
         send_text($urandom_range(0, 9) != 0);
         since_cfg += text_buf.size();
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_text();
      $display("Checked %0d results from %0d strings: %0d glyphs (%0d full-width), %0d leads,",
               results_seen, strings_sent, kind_seen[KIND_GLYPH], full_seen,
               kind_seen[KIND_LEAD]);
      $display("%0d wide spaces, %0d newlines, %0d ignored; %0d register writes, %0d stall cycles.",
               kind_seen[KIND_ADVANCE], kind_seen[KIND_NEWLINE], kind_seen[KIND_IGNORED],
               cfg_writes, input_stalls);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected.", expected_layout.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sgl_pkg.sv
rtl/sgl_front.sv
rtl/sgl_queue.sv
rtl/sgl_back.sv
rtl/sjis_glyph_layout.sv
rtl/sgl_checker.sv
tb/sjis_glyph_layout_tb.sv
